### hw/rtl/dq_pkg.sv
// Shared types and constants of the double-ended queue.
// Request kinds, status codes and the control record between ring logic and top.
// No dependencies.
`timescale 1ns / 1ps

package dq_pkg;

  // Fixed field widths of the stream payload
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned TDATA_W = 40;

  localparam int unsigned DEFAULT_DEPTH = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_TRUNCATE   = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_BADPOS = 2'd3
  } status_e;

  // Outcome of one request as seen by the top level
  typedef struct packed {
    status_e          status;
    logic [LEN_W-1:0] length;
    logic             pop;     // the request is a successful pop and needs a slot read
  } ring_rsp_t;

endpackage

### hw/rtl/dq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/dq_ring.sv
// Ring pointer and fill count of the double-ended queue.
// Decodes a request, updates front index and count, drives RAM addresses.
// Depends on dq_pkg.
`timescale 1ns / 1ps

module dq_ring
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = DEFAULT_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_i,
  input  kind_e                    kind_i,
  input  logic [WORD_W-1:0]        value_i,
  input  logic [POS_W-1:0]         position_i,
  output ring_rsp_t                rsp_o,
  output logic                     we_o,
  output logic [$clog2(DEPTH)-1:0] waddr_o,
  output logic [WORD_W-1:0]        wdata_o,
  output logic [$clog2(DEPTH)-1:0] raddr_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [IW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic          full, empty;
  logic [IW-1:0] front_dec, front_inc, back_slot, last_slot;
  logic [CW:0]   sum_back, sum_last;

  // Reduce a sum below twice the depth to a ring index
  function automatic logic [IW-1:0] wrap(input logic [CW:0] s);
    logic [CW:0] r;
    r = (32'(s) >= DEPTH) ? (s - (CW+1)'(DEPTH)) : s;
    return IW'(r);
  endfunction

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : (front_q - 1'b1);
  assign front_inc = (front_q == IW'(DEPTH - 1)) ? '0 : (front_q + 1'b1);
  assign sum_back  = (CW+1)'(front_q) + (CW+1)'(count_q);
  assign sum_last  = sum_back - 1'b1;
  assign back_slot = wrap(sum_back);
  assign last_slot = wrap(sum_last);

  assign wdata_o = value_i;

  always_comb begin
    front_d       = front_q;
    count_d       = count_q;
    we_o          = 1'b0;
    waddr_o       = back_slot;
    raddr_o       = front_q;
    rsp_o.status  = STAT_OK;
    rsp_o.pop     = 1'b0;
    case (kind_i)
      KIND_PUSH_FRONT: begin
        if (full) begin
          rsp_o.status = STAT_FULL;
        end else begin
          front_d = front_dec;
          count_d = count_q + 1'b1;
          we_o    = req_i;
          waddr_o = front_dec;
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          rsp_o.status = STAT_FULL;
        end else begin
          count_d = count_q + 1'b1;
          we_o    = req_i;
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          rsp_o.status = STAT_EMPTY;
        end else begin
          front_d   = front_inc;
          count_d   = count_q - 1'b1;
          rsp_o.pop = 1'b1;
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          rsp_o.status = STAT_EMPTY;
        end else begin
          count_d   = count_q - 1'b1;
          raddr_o   = last_slot;
          rsp_o.pop = 1'b1;
        end
      end
      KIND_TRUNCATE: begin
        if (32'(position_i) >= 32'(count_q)) begin
          rsp_o.status = STAT_BADPOS;
        end else begin
          count_d = CW'(position_i);
        end
      end
      default: begin
      end
    endcase
    rsp_o.length = LEN_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (req_i) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

endmodule

### hw/rtl/double_ended_queue.sv
// Double-ended queue top: stream ports, request sequencer, result register.
// Push, truncate and failed requests load the result register from the request;
// a successful pop reads the slot RAM first and blocks new requests until done.
// Throughput: one request per cycle while the result stream is ready.
// Reset: front index and count clear at once; slot RAM keeps its contents.
`timescale 1ns / 1ps

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH = DEFAULT_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // [31:0] value, [35:32] position
  input  logic [KIND_W-1:0]  s_axis_tuser,   // [2:0] kind
  // Result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // [31:0] popped, [36:32] length
  output logic [STAT_W-1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned IW = $clog2(DEPTH);

  // Sequencer: idle takes requests, read waits on RAM data for a pop
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic              fire;
  ring_rsp_t         rsp;
  logic              we;
  logic [IW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata;

  logic              out_valid_q, out_valid_d;
  status_e           status_q;
  logic [WORD_W-1:0] popped_q;
  logic [LEN_W-1:0]  length_q;

  // Accept only while idle and the result register is free or draining
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign fire          = s_axis_tvalid && s_axis_tready;

  dq_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (fire),
    .kind_i     (kind_e'(s_axis_tuser)),
    .value_i    (s_axis_tdata[WORD_W-1:0]),
    .position_i (s_axis_tdata[WORD_W+POS_W-1:WORD_W]),
    .rsp_o      (rsp),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr)
  );

  // Slot storage; a pop reads on its accept edge, data arrives next cycle
  dq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (fire && rsp.pop),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Control: next sequencer state and result valid
  always_comb begin
    state_d     = state_q;
    // Drop the held result once it is taken
    out_valid_d = out_valid_q && !m_axis_tready;
    case (state_q)
      ST_IDLE: begin
        if (fire) begin
          if (rsp.pop) begin
            state_d = ST_READ;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_READ: begin
        // Result register is empty here: advance with the read data
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: hold status and length from the request, popped word from RAM (zero if no pop)
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= rsp.status;
      length_q <= rsp.length;
      popped_q <= '0;
    end else if (state_q == ST_READ) begin
      popped_q <= rdata;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {{(TDATA_W - WORD_W - LEN_W){1'b0}}, length_q, popped_q};

  // A pending read blocks new requests
  a_read_blocks_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !s_axis_tready)
    else $error("request accepted while a slot read is pending");

  // An accepted pop goes to the read state
  a_pop_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && rsp.pop) |=> (state_q == ST_READ))
    else $error("pop did not enter read state");

  // The result register is free while a read is pending
  a_read_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !out_valid_q)
    else $error("result register occupied during slot read");

  // A reported length never exceeds the depth
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (32'(length_q) <= DEPTH))
    else $error("reported length beyond depth");

endmodule
